/* src/cross_peak_clip_filter_core_defines.svh */
`ifndef CROSS_PEAK_CLIP_FILTER_CORE_DEFINES_SVH
`define CROSS_PEAK_CLIP_FILTER_CORE_DEFINES_SVH

// Assertion helpers shared by the filter modules.
// An implication that is checked in the same cycle.
`define CPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cross peak clip filter: same-cycle check failed");

// An implication whose consequence is checked in the next cycle.
`define CPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cross peak clip filter: next-cycle check failed");

`endif

/* src/cpc_pkg.sv */
`timescale 1ns / 1ps

package cpc_pkg;

  localparam int PORT_BITS  = 32;
  localparam int COLS_REG_W = 11;
  localparam int ROWS_REG_W = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd1024;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 16'd1;

  typedef enum logic {
    REG_FRAME_COLS,
    REG_FRAME_ROWS
  } cpc_reg_t;

  // Results still owed for one beat, in emission order lag, step, fin.
  typedef struct packed {
    logic lag;
    logic step;
    logic fin;
  } cpc_pend_t;

  // Classification of one input beat, made at the front.
  typedef struct packed {
    cpc_pend_t pend;
    logic      up_ok;
    logic      left_ok;
    logic      right_ok;
    logic      step_left;
  } cpc_cls_t;

endpackage

/* src/cpc_ram.sv */
`timescale 1ns / 1ps

module cpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/cpc_front.sv */
`timescale 1ns / 1ps

module cpc_front #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 32,
  localparam int CIW  = $clog2(MAX_COLS),
  localparam int COLW = $clog2(MAX_COLS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic [COLW-1:0]                 cols_eff,
  input  logic [cpc_pkg::ROWS_REG_W-1:0]  rows_eff,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           px_in,
  input  logic                            q_full,
  output logic                            q_push,
  output cpc_pkg::cpc_cls_t               q_cls,
  output logic [CIW-1:0]                  q_col,
  output logic [PIXEL_BITS-1:0]           q_px,
  output logic [PIXEL_BITS-1:0]           q_right
);

  import cpc_pkg::*;

  logic [CIW-1:0]        col;
  logic [ROWS_REG_W-1:0] row;

  logic                  s1_valid;
  cpc_cls_t              s1_cls;
  logic [CIW-1:0]        s1_col;
  logic [PIXEL_BITS-1:0] s1_px;
  logic                  s1_byp;

  logic                  accept;
  logic [COLW-1:0]       col_p1;
  logic                  row_end;
  logic                  last_row;
  cpc_cls_t              cls_now;
  logic [CIW-1:0]        rd_addr;
  logic [PIXEL_BITS-1:0] ram_rdata;

  assign in_stall = s1_valid & q_full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = s1_valid & ~q_full;

  assign col_p1   = COLW'(col) + COLW'(1);
  assign row_end  = (col_p1 == cols_eff);
  assign last_row = ((row + ROWS_REG_W'(1)) == rows_eff);

  always_comb begin
    cls_now.pend.lag  = (row != '0);
    cls_now.pend.step = last_row & (col != '0);
    cls_now.pend.fin  = last_row & row_end;
    cls_now.up_ok     = (row >= ROWS_REG_W'(2));
    cls_now.left_ok   = (col != '0);
    cls_now.right_ok  = ~row_end;
    cls_now.step_left = (COLW'(col) >= COLW'(2));
  end

  // The right neighbour of the next beat is fetched now; at a row end that is
  // column zero of the row just finished.
  assign rd_addr = row_end ? '0 : col_p1[CIW-1:0];

  cpc_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_COLS)
  ) u_centre_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(px_in),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= last_row ? '0 : (row + ROWS_REG_W'(1));
      end else begin
        col <= col_p1[CIW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls <= cls_now;
      s1_col <= col;
      s1_px  <= px_in;
      s1_byp <= row_end & (col == '0);
    end
  end

  assign q_cls   = s1_cls;
  assign q_col   = s1_col;
  assign q_px    = s1_px;
  // With a single column the fetch hits the entry being written.
  assign q_right = s1_byp ? s1_px : ram_rdata;

endmodule

/* src/cpc_queue.sv */
`timescale 1ns / 1ps
`include "cross_peak_clip_filter_core_defines.svh"

module cpc_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : (wptr + PW'(1));
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : (rptr + PW'(1));
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  `CPC_ASSERT_IMPL(a_no_overflow, clk, rst, full, !push)
  `CPC_ASSERT_IMPL(a_no_underflow, clk, rst, pop, !empty)
  `CPC_ASSERT_NEXT(a_fill_step, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

/* src/cpc_back.sv */
`timescale 1ns / 1ps
`include "cross_peak_clip_filter_core_defines.svh"

module cpc_back #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 32,
  localparam int CIW = $clog2(MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  cpc_pkg::cpc_cls_t     q_cls,
  input  logic [CIW-1:0]        q_col,
  input  logic [PIXEL_BITS-1:0] q_px,
  input  logic [PIXEL_BITS-1:0] q_right,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] res_px,
  output logic                  res_last,
  output logic                  res_eof
);

  import cpc_pkg::*;

  function automatic logic [PIXEL_BITS-1:0] clip_peak(
    input logic [PIXEL_BITS-1:0]      v,
    input logic [3:0]                 present,
    input logic [3:0][PIXEL_BITS-1:0] nb
  );
    logic [PIXEL_BITS-1:0] largest;
    logic                  peak;
    largest = '0;
    peak    = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (present[k]) begin
        if (nb[k] > largest) begin
          largest = nb[k];
        end
        if (v <= nb[k]) begin
          peak = 1'b0;
        end
      end
    end
    return peak ? largest : v;
  endfunction

  logic                  b_valid;
  cpc_cls_t              b_cls;
  cpc_pend_t             b_pend;
  logic [CIW-1:0]        b_col;
  logic [PIXEL_BITS-1:0] b_px;
  logic [PIXEL_BITS-1:0] b_right;
  logic                  b_fwd;

  logic [PIXEL_BITS-1:0] c_cur;
  logic [PIXEL_BITS-1:0] px_prev;
  logic [PIXEL_BITS-1:0] lag_prev;
  logic [PIXEL_BITS-1:0] lag_cur;
  logic [PIXEL_BITS-1:0] step_prev;
  logic [PIXEL_BITS-1:0] step_cur;
  logic [PIXEL_BITS-1:0] up_rd;

  logic                  out_free;
  logic                  sel_lag;
  logic                  sel_step;
  logic                  sel_fin;
  logic                  emit;
  logic                  load_last;
  logic                  adv;
  logic                  up_we;
  logic                  fwd_next;
  cpc_pend_t             pend_next;

  logic [PIXEL_BITS-1:0]            cp_v;
  logic [3:0]                       cp_present;
  logic [3:0][PIXEL_BITS-1:0]       cp_nb;
  logic [PIXEL_BITS-1:0]            res;

  assign out_free = ~out_valid | ~out_stall;
  assign sel_lag  = b_pend.lag;
  assign sel_step = ~b_pend.lag & b_pend.step;
  assign sel_fin  = ~b_pend.lag & ~b_pend.step & b_pend.fin;
  assign emit     = b_valid & (b_pend != '0) & out_free;

  always_comb begin
    pend_next = b_pend;
    if (sel_lag) begin
      pend_next.lag = 1'b0;
    end else if (sel_step) begin
      pend_next.step = 1'b0;
    end else begin
      pend_next.fin = 1'b0;
    end
  end

  assign load_last = (pend_next == '0);
  assign adv       = b_valid & ((b_pend == '0) | (emit & load_last));
  assign q_pop     = ~q_empty & (~b_valid | adv);
  assign up_we     = emit & sel_lag;
  assign fwd_next  = up_we & adv & (b_col == q_col);

  // Neighbour order in cp_nb: right, down, left, up.
  always_comb begin
    cp_v       = b_px;
    cp_present = '0;
    cp_nb      = '0;
    if (sel_lag) begin
      cp_v       = c_cur;
      cp_present = {b_cls.right_ok, 1'b1, b_cls.left_ok, b_cls.up_ok};
      cp_nb      = {b_right, b_px, lag_prev, (b_fwd ? lag_prev : up_rd)};
    end else if (sel_step) begin
      cp_v       = px_prev;
      cp_present = {1'b1, 1'b0, b_cls.step_left, b_cls.pend.lag};
      cp_nb      = {b_px, b_px, step_prev, lag_prev};
    end else begin
      cp_present = {1'b0, 1'b0, b_cls.left_ok, b_cls.pend.lag};
      cp_nb      = {b_px, b_px, step_cur, lag_cur};
    end
  end

  assign res = clip_peak(cp_v, cp_present, cp_nb);

  cpc_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_COLS)
  ) u_upper_ram (
    .clk  (clk),
    .we   (up_we),
    .waddr(b_col),
    .wdata(res),
    .re   (q_pop),
    .raddr(q_col),
    .rdata(up_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_pend  <= '0;
    end else if (q_pop) begin
      b_valid <= 1'b1;
      b_pend  <= q_cls.pend;
    end else begin
      if (adv) begin
        b_valid <= 1'b0;
      end
      if (emit) begin
        b_pend <= pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cls   <= q_cls;
      b_col   <= q_col;
      b_px    <= q_px;
      b_right <= q_right;
      b_fwd   <= fwd_next;
    end
    if (emit && sel_lag) begin
      lag_cur <= res;
    end
    if (emit && sel_step) begin
      step_cur <= res;
    end
    if (adv) begin
      c_cur     <= b_right;
      px_prev   <= b_px;
      lag_prev  <= (emit && sel_lag) ? res : lag_cur;
      step_prev <= (emit && sel_step) ? res : step_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_px   <= res;
      res_last <= load_last;
      res_eof  <= sel_fin;
    end
  end

  `CPC_ASSERT_IMPL(a_eof_is_last, clk, rst, out_valid && res_eof, res_last)
  `CPC_ASSERT_NEXT(a_run_holds, clk, rst, emit && !load_last, b_valid)
  `CPC_ASSERT_IMPL(a_fin_after_rest, clk, rst, emit && sel_fin, !b_pend.lag && !b_pend.step)

endmodule

/* src/cross_peak_clip_filter_core.sv */
`timescale 1ns / 1ps
// An accepted beat passes the front register, the queue and the back register, and its results
// leave through the output register; a beat with two or three results sends them in turn.
// One beat per cycle while each beat gives at most one result and neither the output stalls
// nor the queue is full; beats of the last row give more results, sent one per output beat.
// Reset: synchronous rst clears control state and sets 1024 columns, 1 row; line buffers are
// not cleared and need no clearing pass.
module cross_peak_clip_filter_core #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // Pixel input stream.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cpc_pkg::PORT_BITS-1:0]  pixel_in,
  // Filtered pixel output stream.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cpc_pkg::PORT_BITS-1:0]  pixel_out,
  output logic                           last_of_run,
  output logic                           end_of_frame
);

  import cpc_pkg::*;

  localparam int CIW     = $clog2(MAX_COLS);
  localparam int COLW    = $clog2(MAX_COLS + 1);
  localparam int Q_DEPTH = 2;
  localparam int CLS_W   = $bits(cpc_cls_t);
  localparam int QW      = CLS_W + CIW + 2 * PIXEL_BITS;

  // Register file. Any write restarts the frame at row zero, column zero.
  logic [COLS_REG_W-1:0] frame_cols;
  logic [ROWS_REG_W-1:0] frame_rows;
  logic [COLW-1:0]       cols_eff;
  logic [ROWS_REG_W-1:0] rows_eff;
  logic                  cfg_wr;
  cpc_reg_t              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cpc_reg_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= COLS_RESET;
      frame_rows <= ROWS_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FRAME_COLS: frame_cols <= pwdata[COLS_REG_W-1:0];
        REG_FRAME_ROWS: frame_rows <= pwdata[ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_COLS: prdata = APB_DATA_W'(frame_cols);
      REG_FRAME_ROWS: prdata = APB_DATA_W'(frame_rows);
      default:        prdata = '0;
    endcase
  end

  // A column count of zero acts as one, and one above the line buffer size is clamped.
  always_comb begin
    if (frame_cols == '0) begin
      cols_eff = COLW'(1);
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      cols_eff = COLW'(MAX_COLS);
    end else begin
      cols_eff = COLW'(frame_cols);
    end
  end

  assign rows_eff = (frame_rows == '0) ? ROWS_REG_W'(1) : frame_rows;

  // The front tracks the raster position, classifies each beat and fetches the
  // unfiltered pixels of the row above from the centre line buffer.
  logic                  f_push;
  cpc_cls_t              f_cls;
  logic [CIW-1:0]        f_col;
  logic [PIXEL_BITS-1:0] f_px;
  logic [PIXEL_BITS-1:0] f_right;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [QW-1:0]         q_rdata;
  cpc_cls_t              b_cls;
  logic [CIW-1:0]        b_col;
  logic [PIXEL_BITS-1:0] b_px;
  logic [PIXEL_BITS-1:0] b_right;
  logic [PIXEL_BITS-1:0] res_px;

  cpc_front #(
    .MAX_COLS  (MAX_COLS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .cols_eff(cols_eff),
    .rows_eff(rows_eff),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .px_in   (pixel_in[PIXEL_BITS-1:0]),
    .q_full  (q_full),
    .q_push  (f_push),
    .q_cls   (f_cls),
    .q_col   (f_col),
    .q_px    (f_px),
    .q_right (f_right)
  );

  // A short queue lets the front keep taking pixels while the back sends the
  // extra results of the last row.
  cpc_queue #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata({f_cls, f_col, f_px, f_right}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign {b_cls, b_col, b_px, b_right} = q_rdata;

  // The back filters the lagging row against the updated line buffer and
  // sends one result per output beat.
  cpc_back #(
    .MAX_COLS  (MAX_COLS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_cls    (b_cls),
    .q_col    (b_col),
    .q_px     (b_px),
    .q_right  (b_right),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_px   (res_px),
    .res_last (last_of_run),
    .res_eof  (end_of_frame)
  );

  assign pixel_out = PORT_BITS'(res_px);

endmodule
